### src/wcr_pkg.sv
// ----------------------------------------------------------------------------
// wcr_pkg
// Shared types and constants for the wall column ray caster.
// ----------------------------------------------------------------------------
package wcr_pkg;

   // map size defaults
   localparam int MAP_W_DEF = 16;
   localparam int MAP_H_DEF = 16;

   // march step in Q16 map cells (about 0.05)
   localparam int STEP_Q16 = 3277;
   // distance of two cells in Q16, below which the slice fills the screen
   localparam int TWO_CELLS_Q16 = 131072;

   // register reset values
   localparam logic [11:0] SCREEN_H_RST = 12'd480;
   localparam logic [10:0] TEX_W_RST    = 11'd64;
   localparam logic [9:0]  MAX_STEPS_RST = 10'd320;

   // register indexes
   typedef enum logic [2:0] {
      CSR_PLAYER_X  = 3'd0,
      CSR_PLAYER_Y  = 3'd1,
      CSR_SCREEN_H  = 3'd2,
      CSR_TEX_W     = 3'd3,
      CSR_MAX_STEPS = 3'd4
   } csr_index_type;

   // input modes
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_CAST  = 1'b1;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_ADV,
      S_CHK,
      S_DIST,
      S_MUL,
      S_FRAC,
      S_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic write_cell;
      logic start;
      logic adv;
      logic finish;
      logic calc_dist;
      logic mul;
      logic frac;
      logic div;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic zero_steps;
      logic hit;
      logic outside;
      logic last_step;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

### src/wcr_ctrl.sv
// ----------------------------------------------------------------------------
// wcr_ctrl
// Sequencer: map clear, march loop, slice math and result hand-off.
// ----------------------------------------------------------------------------
module wcr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   output logic                req_stall,
   input  wcr_pkg::status_type status,
   output wcr_pkg::cmd_type    cmd
);

   wcr_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wcr_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         wcr_pkg::S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_done) state_in = wcr_pkg::S_IDLE;
         end
         wcr_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (req_mode == wcr_pkg::MODE_WRITE) begin
                  cmd.write_cell = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  state_in  = status.zero_steps ? wcr_pkg::S_DIST : wcr_pkg::S_ADV;
               end
            end
         end
         wcr_pkg::S_ADV: begin
            cmd.adv  = 1'b1;
            state_in = wcr_pkg::S_CHK;
         end
         wcr_pkg::S_CHK: begin
            if (status.hit || status.outside) begin
               cmd.finish = 1'b1;
               state_in   = wcr_pkg::S_DIST;
            end else if (status.last_step) begin
               state_in = wcr_pkg::S_DIST;
            end else begin
               state_in = wcr_pkg::S_ADV;
            end
         end
         wcr_pkg::S_DIST: begin
            cmd.calc_dist = 1'b1;
            state_in      = wcr_pkg::S_MUL;
         end
         wcr_pkg::S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = wcr_pkg::S_FRAC;
         end
         wcr_pkg::S_FRAC: begin
            cmd.frac = 1'b1;
            state_in = wcr_pkg::S_DIV;
         end
         wcr_pkg::S_DIV: begin
            cmd.div = 1'b1;
            if (status.div_done) state_in = wcr_pkg::S_OUT;
         end
         wcr_pkg::S_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = wcr_pkg::S_IDLE;
            end
         end
         default: state_in = wcr_pkg::S_IDLE;
      endcase
   end

endmodule

### src/wcr_datapath.sv
// ----------------------------------------------------------------------------
// wcr_datapath
// Registers, wall map, march accumulators, divider and output stage.
// ----------------------------------------------------------------------------
module wcr_datapath #(
   parameter int MAP_W = wcr_pkg::MAP_W_DEF,
   parameter int MAP_H = wcr_pkg::MAP_H_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  wcr_pkg::cmd_type    cmd,
   output wcr_pkg::status_type status,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data,
   input  logic [3:0]          req_cell_x,
   input  logic [3:0]          req_cell_y,
   input  logic                req_cell_wall,
   input  logic [10:0]         req_column,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [10:0]         rsp_out_column,
   output logic [10:0]         rsp_top_row,
   output logic [11:0]         rsp_bottom_row,
   output logic [9:0]          rsp_tex_column,
   output logic                rsp_left_map
);

   localparam int DEPTH = MAP_W * MAP_H;
   localparam int AW    = $clog2(DEPTH);

   // configuration
   logic [23:0] px_ff, py_ff;
   logic [11:0] h_ff;
   logic [10:0] w_ff;
   logic [9:0]  ms_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         h_ff  <= wcr_pkg::SCREEN_H_RST;
         w_ff  <= wcr_pkg::TEX_W_RST;
         ms_ff <= wcr_pkg::MAX_STEPS_RST;
      end else if (csr_valid) begin
         case (csr_index)
            wcr_pkg::CSR_PLAYER_X:  px_ff <= csr_data;
            wcr_pkg::CSR_PLAYER_Y:  py_ff <= csr_data;
            wcr_pkg::CSR_SCREEN_H:  h_ff  <= csr_data[11:0];
            wcr_pkg::CSR_TEX_W:     w_ff  <= csr_data[10:0];
            wcr_pkg::CSR_MAX_STEPS: ms_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // map clear sweep after reset
   logic [AW-1:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end
   assign status.clear_done = (clr_ff == AW'(DEPTH - 1));

   // ray state
   logic [10:0]        col_ff;
   logic signed [15:0] dx_ff, dy_ff;
   logic signed [28:0] incx_ff, incy_ff;
   logic signed [39:0] posx_ff, posy_ff;
   logic signed [9:0]  cx_ff, lastx_ff;
   logic [9:0]         k_ff, steps_ff;
   logic               left_ff, outside_ff, rd_ff;

   logic signed [12:0] step_s;
   logic signed [39:0] posx_in, posy_in;
   logic signed [9:0]  ncx, ncy;
   logic               in_map;
   logic [17:0]        ra_wide, wa_wide;
   logic [AW-1:0]      ra;
   logic               cell_in_map;

   assign step_s  = 13'(wcr_pkg::STEP_Q16);
   assign posx_in = posx_ff + 40'(incx_ff);
   assign posy_in = posy_ff + 40'(incy_ff);
   assign ncx     = posx_in[39:30];
   assign ncy     = posy_in[39:30];
   assign in_map  = !ncx[9] && !ncy[9] && (ncx[8:0] < 9'(MAP_W)) && (ncy[8:0] < 9'(MAP_H));
   assign ra_wide = 18'(ncy[8:0]) * 18'(MAP_W) + 18'(ncx[8:0]);
   assign ra      = ra_wide[AW-1:0];
   assign wa_wide = 18'(req_cell_y) * 18'(MAP_W) + 18'(req_cell_x);
   assign cell_in_map = (9'(req_cell_x) < 9'(MAP_W)) && (9'(req_cell_y) < 9'(MAP_H));

   // wall map memory
   logic          mem [DEPTH];
   logic          mem_we, mem_wd;
   logic [AW-1:0] mem_wa;

   always_comb begin
      mem_we = cmd.clear || (cmd.write_cell && cell_in_map);
      mem_wa = cmd.clear ? clr_ff : wa_wide[AW-1:0];
      mem_wd = cmd.clear ? 1'b0 : req_cell_wall;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      rd_ff <= mem[ra];
   end

   // march
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         col_ff   <= req_column;
         dx_ff    <= req_dir_x;
         dy_ff    <= req_dir_y;
         incx_ff  <= req_dir_x * step_s;
         incy_ff  <= req_dir_y * step_s;
         posx_ff  <= {2'b00, px_ff, 14'd0};
         posy_ff  <= {2'b00, py_ff, 14'd0};
         cx_ff    <= {2'b00, px_ff[23:16]};
         lastx_ff <= {2'b00, px_ff[23:16]};
         k_ff     <= '0;
         steps_ff <= ms_ff;
         left_ff  <= 1'b0;
      end else if (cmd.adv) begin
         posx_ff    <= posx_in;
         posy_ff    <= posy_in;
         lastx_ff   <= cx_ff;
         cx_ff      <= ncx;
         outside_ff <= !in_map;
         k_ff       <= k_ff + 1'b1;
      end else if (cmd.finish) begin
         if (outside_ff) begin
            left_ff <= 1'b1;
         end else begin
            steps_ff <= k_ff;
         end
      end
   end

   assign status.zero_steps = (ms_ff == 10'd0);
   assign status.hit        = rd_ff && !outside_ff;
   assign status.outside    = outside_ff;
   assign status.last_step  = (k_ff == ms_ff);

   // distance, hit point product and slice numerator
   logic [21:0]        d_ff;
   logic signed [38:0] prod_ff;
   logic [15:0]        pl_ff;
   logic [33:0]        num_ff;
   logic [29:0]        f_ff;
   logic signed [15:0] dsel;
   logic               ychg;

   assign ychg = (cx_ff != lastx_ff);
   assign dsel = ychg ? dy_ff : dx_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc_dist) begin
         d_ff <= 22'(steps_ff * 12'(wcr_pkg::STEP_Q16));
      end
      if (cmd.mul) begin
         prod_ff <= dsel * $signed({1'b0, d_ff});
         pl_ff   <= ychg ? py_ff[15:0] : px_ff[15:0];
         if (d_ff > 22'(wcr_pkg::TWO_CELLS_Q16)) begin
            num_ff <= 34'(h_ff * (d_ff - 22'(wcr_pkg::TWO_CELLS_Q16)));
         end else begin
            num_ff <= '0;
         end
      end
      if (cmd.frac) begin
         f_ff <= {pl_ff, 14'd0} + prod_ff[29:0];
      end
   end

   // restoring divider, one quotient bit per cycle; zero distance gives zero
   logic [33:0] rem_ff, dsh_ff;
   logic [10:0] q_ff;
   logic [3:0]  dcnt_ff;
   logic [40:0] texp_ff;

   always_ff @(posedge clock) begin
      if (cmd.frac) begin
         rem_ff  <= num_ff;
         dsh_ff  <= 34'({d_ff, 1'b0}) << 10;
         q_ff    <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div) begin
         if ((rem_ff >= dsh_ff) && (dsh_ff != '0)) begin
            rem_ff <= rem_ff - dsh_ff;
            q_ff   <= {q_ff[9:0], 1'b1};
         end else begin
            q_ff <= {q_ff[9:0], 1'b0};
         end
         dsh_ff  <= dsh_ff >> 1;
         dcnt_ff <= dcnt_ff + 1'b1;
         texp_ff <= 41'(f_ff) * 41'(w_ff);
      end
   end
   assign status.div_done = (dcnt_ff == 4'd10);

   // texture column clamp: floor(0.999 w) = w - ceil(w / 1000)
   logic [10:0] tex_raw, tex_lim, tex_min;
   logic [1:0]  ceil_k;
   logic [9:0]  tex_sat;

   always_comb begin
      tex_raw = texp_ff[40:30];
      if (w_ff == 11'd0)          ceil_k = 2'd0;
      else if (w_ff <= 11'd1000)  ceil_k = 2'd1;
      else if (w_ff <= 11'd2000)  ceil_k = 2'd2;
      else                        ceil_k = 2'd3;
      tex_lim = w_ff - 11'(ceil_k);
      tex_min = (tex_raw > tex_lim) ? tex_lim : tex_raw;
      tex_sat = (tex_min > 11'd1023) ? 10'd1023 : tex_min[9:0];
   end

   // output register
   logic rsp_valid_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_out_column <= col_ff;
         rsp_top_row    <= q_ff;
         rsp_bottom_row <= h_ff - 12'(q_ff);
         rsp_tex_column <= tex_sat;
         rsp_left_map   <= left_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### src/wall_column_raycaster.sv
// ----------------------------------------------------------------------------
// wall_column_raycaster
// Fixed step ray march over a wall grid, giving one wall slice per ray.
// ----------------------------------------------------------------------------
// After reset the wall map is cleared cell by cell, during which no item is
// taken (register writes are). A map write leaves the block idle. A ray runs
// up to max_steps march steps (step advance with the registered map read,
// then hit check), then the distance and hit point multiplies, the slice
// height divider and the output load, which waits for a free output register.
// One ray is worked at a time; the next item is taken while the last result
// still waits in the output register.
module wall_column_raycaster #(
   parameter int MAP_W = wcr_pkg::MAP_W_DEF,
   parameter int MAP_H = wcr_pkg::MAP_H_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic [3:0]         req_cell_x,
   input  logic [3:0]         req_cell_y,
   input  logic               req_cell_wall,
   input  logic [10:0]        req_column,
   input  logic signed [15:0] req_dir_x,
   input  logic signed [15:0] req_dir_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [10:0]        rsp_out_column,
   output logic [10:0]        rsp_top_row,
   output logic [11:0]        rsp_bottom_row,
   output logic [9:0]         rsp_tex_column,
   output logic               rsp_left_map
);

   wcr_pkg::cmd_type    cmd;
   wcr_pkg::status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   wcr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   wcr_datapath #(
      .MAP_W (MAP_W),
      .MAP_H (MAP_H)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_cell_x     (req_cell_x),
      .req_cell_y     (req_cell_y),
      .req_cell_wall  (req_cell_wall),
      .req_column     (req_column),
      .req_dir_x      (req_dir_x),
      .req_dir_y      (req_dir_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_column (rsp_out_column),
      .rsp_top_row    (rsp_top_row),
      .rsp_bottom_row (rsp_bottom_row),
      .rsp_tex_column (rsp_tex_column),
      .rsp_left_map   (rsp_left_map)
   );

   // a ray transfer keeps the block busy in the next cycle
   a_ray_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_mode == wcr_pkg::MODE_CAST) |=> req_stall)
      else $error("ray accepted but block not busy");

   // slice top never below its bottom
   a_slice_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (12'(rsp_top_row) <= rsp_bottom_row))
      else $error("slice top row past bottom row");

   // a result is only loaded when the output register is free
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid || !rsp_stall))
      else $error("result loaded over a pending result");

endmodule
